### rtl/core/tcaoq_pkg.sv
package tcaoq_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_TDATA_BITS = 40;
  localparam int OUT_TDATA_BITS = 40;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [1:0] REQ_EITHER  = 2'd0;
  localparam logic [1:0] REQ_CLASS_A = 2'd1;
  localparam logic [1:0] REQ_CLASS_B = 2'd2;
  localparam logic [1:0] REQ_INVALID = 2'd3;

  localparam logic CLASS_A = 1'b0;
  localparam logic CLASS_B = 1'b1;

  typedef enum logic [1:0] {
    ST_SERVED  = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_PUSHED  = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

### rtl/core/two_class_age_ordered_queue.sv
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   item_value[31:0], request_class[33:32], 0   mode[0]
// m_axis   out  served_value[31:0], served_class[32], 0     status[1:0]
//
// One request per cycle unless m_axis stalls; its result is registered and appears the cycle after acceptance.
// Push and pop work on a row of cells per class, the head always in the first cell.
// Reset empties both rows of cells, clears the stamp counter and drops any held result.
// s_axis_tready follows the output register: a new item is taken while the
// result is empty or being taken.
module two_class_age_ordered_queue
  import tcaoq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int STAMP_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // item_value, request_class
  input  logic [0:0]                s_axis_tuser,  // mode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,  // served_value, served_class
  output logic [1:0]                m_axis_tuser   // status
);

  logic                         accept;
  logic                         mode;
  logic signed [VALUE_BITS-1:0] item_value;
  logic        [1:0]            request_class;
  logic                         is_a;

  cell_ctrl_t                   a_ctrl, b_ctrl;
  logic                         a_valid, b_valid, a_full, b_full;
  logic signed [VALUE_BITS-1:0] a_value, b_value;
  logic        [STAMP_BITS-1:0] a_stamp, b_stamp, stamp_diff;
  logic        [STAMP_BITS-1:0] arrival_stamp;

  logic                         pick_valid, pick_b;
  status_t                      status_next;
  logic signed [VALUE_BITS-1:0] value_next;
  logic                         class_next;

  logic                         out_valid;
  status_t                      out_status;
  logic signed [VALUE_BITS-1:0] out_value;
  logic                         out_class;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign mode          = s_axis_tuser[0];
  assign item_value    = s_axis_tdata[VALUE_BITS-1:0];
  assign request_class = s_axis_tdata[VALUE_BITS+1:VALUE_BITS];
  assign is_a          = item_value > 0;
  assign stamp_diff    = a_stamp - b_stamp;

  always_comb begin
    pick_valid = 1'b0;
    pick_b     = 1'b0;
    case (request_class)
      REQ_EITHER: begin
        pick_valid = a_valid || b_valid;
        if (a_valid && b_valid) begin
          pick_b = !stamp_diff[STAMP_BITS-1];
        end else begin
          pick_b = !a_valid;
        end
      end
      REQ_CLASS_A: begin
        pick_valid = a_valid;
        pick_b     = 1'b0;
      end
      REQ_CLASS_B: begin
        pick_valid = b_valid;
        pick_b     = 1'b1;
      end
      default: begin
        pick_valid = 1'b0;
        pick_b     = 1'b0;
      end
    endcase
  end

  always_comb begin
    a_ctrl      = '0;
    b_ctrl      = '0;
    status_next = ST_EMPTY;
    value_next  = '0;
    class_next  = CLASS_A;
    if (mode == MODE_PUSH) begin
      class_next = is_a ? CLASS_A : CLASS_B;
      if ((is_a && a_full) || (!is_a && b_full)) begin
        status_next = ST_DROPPED;
      end else begin
        status_next = ST_PUSHED;
        a_ctrl.push = accept && is_a;
        b_ctrl.push = accept && !is_a;
      end
    end else if (pick_valid) begin
      status_next = ST_SERVED;
      class_next  = pick_b ? CLASS_B : CLASS_A;
      value_next  = pick_b ? b_value : a_value;
      a_ctrl.pop  = accept && !pick_b;
      b_ctrl.pop  = accept && pick_b;
    end
  end

  tcaoq_fifo #(
    .DEPTH     (QUEUE_DEPTH),
    .STAMP_BITS(STAMP_BITS)
  ) u_fifo_a (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (a_ctrl),
    .push_value(item_value),
    .push_stamp(arrival_stamp),
    .head_valid(a_valid),
    .head_value(a_value),
    .head_stamp(a_stamp),
    .full      (a_full)
  );

  tcaoq_fifo #(
    .DEPTH     (QUEUE_DEPTH),
    .STAMP_BITS(STAMP_BITS)
  ) u_fifo_b (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (b_ctrl),
    .push_value(item_value),
    .push_stamp(arrival_stamp),
    .head_valid(b_valid),
    .head_value(b_value),
    .head_stamp(b_stamp),
    .full      (b_full)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_stamp <= '0;
    end else if (a_ctrl.push || b_ctrl.push) begin
      arrival_stamp <= arrival_stamp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_value  <= value_next;
      out_class  <= class_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {{(OUT_TDATA_BITS-VALUE_BITS-1){1'b0}}, out_class, out_value};

endmodule

### rtl/core/tcaoq_cell.sv
module tcaoq_cell
  import tcaoq_pkg::*;
#(
  parameter int STAMP_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cell_ctrl_t                   ctrl,
  input  logic signed [VALUE_BITS-1:0] push_value,
  input  logic        [STAMP_BITS-1:0] push_stamp,
  input  logic                         prev_valid,
  input  logic                         next_valid,
  input  logic signed [VALUE_BITS-1:0] next_value,
  input  logic        [STAMP_BITS-1:0] next_stamp,
  output logic                         valid,
  output logic signed [VALUE_BITS-1:0] value,
  output logic        [STAMP_BITS-1:0] stamp
);

  logic load;

  assign load = ctrl.push && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= next_valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  // shift towards the head on a pop, take the pushed item in the first free cell
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      value <= next_value;
      stamp <= next_stamp;
    end else if (load) begin
      value <= push_value;
      stamp <= push_stamp;
    end
  end

endmodule

### rtl/core/tcaoq_fifo.sv
module tcaoq_fifo
  import tcaoq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int STAMP_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cell_ctrl_t                   ctrl,
  input  logic signed [VALUE_BITS-1:0] push_value,
  input  logic        [STAMP_BITS-1:0] push_stamp,
  output logic                         head_valid,
  output logic signed [VALUE_BITS-1:0] head_value,
  output logic        [STAMP_BITS-1:0] head_stamp,
  output logic                         full
);

  logic                         valid_chain [DEPTH+1];
  logic signed [VALUE_BITS-1:0] value_chain [DEPTH+1];
  logic        [STAMP_BITS-1:0] stamp_chain [DEPTH+1];

  assign valid_chain[DEPTH] = 1'b0;
  assign value_chain[DEPTH] = '0;
  assign stamp_chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = valid_chain[i-1];
    end

    tcaoq_cell #(
      .STAMP_BITS(STAMP_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .push_value(push_value),
      .push_stamp(push_stamp),
      .prev_valid(prev_valid),
      .next_valid(valid_chain[i+1]),
      .next_value(value_chain[i+1]),
      .next_stamp(stamp_chain[i+1]),
      .valid     (valid_chain[i]),
      .value     (value_chain[i]),
      .stamp     (stamp_chain[i])
    );
  end

  assign head_valid = valid_chain[0];
  assign head_value = value_chain[0];
  assign head_stamp = stamp_chain[0];
  assign full       = valid_chain[DEPTH-1];

endmodule
